[rtl/rainbow_value_to_rgb_defines.svh]
// ---------------------------------------------------------------------------
// Rainbow colour mapper assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef RAINBOW_VALUE_TO_RGB_DEFINES_SVH
`define RAINBOW_VALUE_TO_RGB_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define RVR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rainbow mapper: same-cycle check failed");

// next-cycle implication, disabled while rst is high
`define RVR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rainbow mapper: next-cycle check failed");

`endif

[rtl/rvr_pkg.sv]
// ---------------------------------------------------------------------------
// Rainbow colour mapper package
// Widths, register indexes, reset values and pipeline stage types.
// ---------------------------------------------------------------------------
package rvr_pkg;

   localparam int SAMPLE_WIDTH    = 32;
   localparam int CHANNEL_BITS    = 8;
   localparam int QUOT_BITS       = CHANNEL_BITS + 2;
   localparam int REQ_TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((3 * CHANNEL_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_WIDTH  = 1;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_LOW_BOUND  = CSR_ADDR_WIDTH'(0);
   localparam logic [CSR_ADDR_WIDTH-1:0] REG_HIGH_BOUND = CSR_ADDR_WIDTH'(1);

   localparam logic [SAMPLE_WIDTH-1:0] LOW_BOUND_RESET  = SAMPLE_WIDTH'(0);
   localparam logic [SAMPLE_WIDTH-1:0] HIGH_BOUND_RESET = SAMPLE_WIDTH'(65536);
   localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_SIGN      =
      {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   localparam logic [CHANNEL_BITS-1:0] CHAN_MAX  = {CHANNEL_BITS{1'b1}};
   localparam logic [CHANNEL_BITS-1:0] CHAN_ZERO = {CHANNEL_BITS{1'b0}};

   localparam logic [1:0] SEG_BLUE_CYAN    = 2'd0;
   localparam logic [1:0] SEG_CYAN_GREEN   = 2'd1;
   localparam logic [1:0] SEG_GREEN_YELLOW = 2'd2;
   localparam logic [1:0] SEG_YELLOW_RED   = 2'd3;

   typedef enum logic [1:0] {
      KIND_BLUE = 2'd0,
      KIND_RED  = 2'd1,
      KIND_MID  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [SAMPLE_WIDTH-1:0] rem;
      logic [SAMPLE_WIDTH-1:0] den;
      logic [QUOT_BITS-1:0]    quot;
   } stage_type;

endpackage

[rtl/rainbow_value_to_rgb.sv]
// ---------------------------------------------------------------------------
// Rainbow value to RGB mapper
// Signed sample in, blue-cyan-green-yellow-red colour out.
// ---------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | tvalid / tready   | tdata: sample
//  rsp     | out       | tvalid / tready   | tdata: red, green, blue
//  csr     | in        | we (no wait)      | addr 0 low bound, 1 high bound
//
//  One item per cycle while rsp is not stalled; stages: front stage, ten divide
//  steps (one quotient bit each, a 33-bit subtract per step) and the colour stage.
//  Reset clears every stage valid bit and loads the bound reset values.
//  While a result waits on rsp_tready the whole pipeline holds; req_tready
//  stays high whenever the output register is empty or being taken.
// ---------------------------------------------------------------------------
module rainbow_value_to_rgb (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rvr_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,  // [31:0] sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rvr_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,  // red, green, blue
   input  logic                                  csr_we,
   input  logic [rvr_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [rvr_pkg::SAMPLE_WIDTH-1:0]      csr_wdata
);

   logic                              advance;
   logic                              stage_valid [0:rvr_pkg::QUOT_BITS];
   rvr_pkg::stage_type                stage_data  [0:rvr_pkg::QUOT_BITS];
   logic [rvr_pkg::CHANNEL_BITS-1:0]  red;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  green;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  blue;

   // advance the whole pipeline unless a finished result is held
   assign advance    = ~rsp_tvalid | rsp_tready;
   assign req_tready = advance;

   rvr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .enable    (advance),
      .in_valid  (req_tvalid),
      .in_sample (req_tdata[rvr_pkg::SAMPLE_WIDTH-1:0]),
      .out_valid (stage_valid[0]),
      .out_stage (stage_data[0])
   );

   for (genvar i = 0; i < rvr_pkg::QUOT_BITS; i++) begin : g_div
      rvr_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (stage_valid[i]),
         .in_stage  (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_stage (stage_data[i+1])
      );
   end

   rvr_color u_color (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (stage_valid[rvr_pkg::QUOT_BITS]),
      .in_stage  (stage_data[rvr_pkg::QUOT_BITS]),
      .out_valid (rsp_tvalid),
      .out_red   (red),
      .out_green (green),
      .out_blue  (blue)
   );

   assign rsp_tdata = rvr_pkg::RSP_TDATA_WIDTH'({blue, green, red});

endmodule

[rtl/rvr_front.sv]
// ---------------------------------------------------------------------------
// Rainbow mapper front stage
// Holds the bound registers, classifies the sample and sets up the divide.
// ---------------------------------------------------------------------------
module rvr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rvr_pkg::CSR_ADDR_WIDTH-1:0]   csr_addr,
   input  logic [rvr_pkg::SAMPLE_WIDTH-1:0]     csr_wdata,
   input  logic                                 enable,
   input  logic                                 in_valid,
   input  logic [rvr_pkg::SAMPLE_WIDTH-1:0]     in_sample,
   output logic                                 out_valid,
   output rvr_pkg::stage_type                   out_stage
);

   logic [rvr_pkg::SAMPLE_WIDTH-1:0] low_ff;
   logic [rvr_pkg::SAMPLE_WIDTH-1:0] high_ff;
   logic                             valid_ff;
   rvr_pkg::stage_type               stage_ff;
   rvr_pkg::stage_type               stage_in;

   logic [rvr_pkg::SAMPLE_WIDTH-1:0] v_ord;
   logic [rvr_pkg::SAMPLE_WIDTH-1:0] lo_ord;
   logic [rvr_pkg::SAMPLE_WIDTH-1:0] hi_ord;
   logic [rvr_pkg::SAMPLE_WIDTH:0]   lo_diff;
   logic [rvr_pkg::SAMPLE_WIDTH:0]   hi_diff;
   logic                             at_or_below;
   logic                             at_or_above;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= rvr_pkg::LOW_BOUND_RESET;
         high_ff <= rvr_pkg::HIGH_BOUND_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            rvr_pkg::REG_LOW_BOUND:  low_ff  <= csr_wdata;
            rvr_pkg::REG_HIGH_BOUND: high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // offset binary turns signed order into unsigned order
   assign v_ord  = in_sample ^ rvr_pkg::SAMPLE_SIGN;
   assign lo_ord = low_ff ^ rvr_pkg::SAMPLE_SIGN;
   assign hi_ord = high_ff ^ rvr_pkg::SAMPLE_SIGN;

   assign lo_diff = {1'b0, v_ord} - {1'b0, lo_ord};
   assign hi_diff = {1'b0, v_ord} - {1'b0, hi_ord};

   assign at_or_below = lo_diff[rvr_pkg::SAMPLE_WIDTH] |
                        (lo_diff[rvr_pkg::SAMPLE_WIDTH-1:0] == '0);
   assign at_or_above = ~hi_diff[rvr_pkg::SAMPLE_WIDTH];

   always_comb begin
      stage_in.rem  = lo_diff[rvr_pkg::SAMPLE_WIDTH-1:0];
      stage_in.den  = hi_ord - lo_ord;
      stage_in.quot = '0;
      // blue wins over red, so an empty range still gives blue at the low end
      if (at_or_below) begin
         stage_in.kind = rvr_pkg::KIND_BLUE;
      end else if (at_or_above) begin
         stage_in.kind = rvr_pkg::KIND_RED;
      end else begin
         stage_in.kind = rvr_pkg::KIND_MID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[rtl/rvr_div_step.sv]
// ---------------------------------------------------------------------------
// Rainbow mapper divide step
// One registered restoring-division step: one quotient bit per stage.
// ---------------------------------------------------------------------------
module rvr_div_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  rvr_pkg::stage_type in_stage,
   output logic               out_valid,
   output rvr_pkg::stage_type out_stage
);

   logic                             valid_ff;
   rvr_pkg::stage_type               stage_ff;
   rvr_pkg::stage_type               stage_in;
   logic [rvr_pkg::SAMPLE_WIDTH:0]   rem_shift;
   logic [rvr_pkg::SAMPLE_WIDTH:0]   trial;
   logic                             fits;

   assign rem_shift = {in_stage.rem, 1'b0};
   assign trial     = rem_shift - {1'b0, in_stage.den};
   // remainder stays below the divisor, so the trial sign is the borrow
   assign fits      = ~trial[rvr_pkg::SAMPLE_WIDTH];

   always_comb begin
      stage_in      = in_stage;
      stage_in.rem  = fits ? trial[rvr_pkg::SAMPLE_WIDTH-1:0]
                           : rem_shift[rvr_pkg::SAMPLE_WIDTH-1:0];
      stage_in.quot = {in_stage.quot[rvr_pkg::QUOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

[rtl/rvr_color.sv]
// ---------------------------------------------------------------------------
// Rainbow mapper colour stage
// Turns class and scaled position into RGB and holds the output register.
// ---------------------------------------------------------------------------
module rvr_color (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  rvr_pkg::stage_type                in_stage,
   output logic                              out_valid,
   output logic [rvr_pkg::CHANNEL_BITS-1:0]  out_red,
   output logic [rvr_pkg::CHANNEL_BITS-1:0]  out_green,
   output logic [rvr_pkg::CHANNEL_BITS-1:0]  out_blue
);

   logic                              valid_ff;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  red_ff;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  green_ff;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  blue_ff;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  red_in;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  green_in;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  blue_in;
   logic [rvr_pkg::CHANNEL_BITS-1:0]  weight;
   logic [1:0]                        segment;

   assign weight  = in_stage.quot[rvr_pkg::CHANNEL_BITS-1:0];
   assign segment = in_stage.quot[rvr_pkg::QUOT_BITS-1:rvr_pkg::CHANNEL_BITS];

   always_comb begin
      red_in   = rvr_pkg::CHAN_ZERO;
      green_in = rvr_pkg::CHAN_ZERO;
      blue_in  = rvr_pkg::CHAN_MAX;
      case (in_stage.kind)
         rvr_pkg::KIND_RED: begin
            red_in  = rvr_pkg::CHAN_MAX;
            blue_in = rvr_pkg::CHAN_ZERO;
         end
         rvr_pkg::KIND_MID: begin
            case (segment)
               rvr_pkg::SEG_BLUE_CYAN: begin
                  green_in = weight;
               end
               rvr_pkg::SEG_CYAN_GREEN: begin
                  green_in = rvr_pkg::CHAN_MAX;
                  blue_in  = rvr_pkg::CHAN_MAX - weight;
               end
               rvr_pkg::SEG_GREEN_YELLOW: begin
                  red_in   = weight;
                  green_in = rvr_pkg::CHAN_MAX;
                  blue_in  = rvr_pkg::CHAN_ZERO;
               end
               default: begin
                  red_in   = rvr_pkg::CHAN_MAX;
                  green_in = rvr_pkg::CHAN_MAX - weight;
                  blue_in  = rvr_pkg::CHAN_ZERO;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

[rtl/rvr_checker.sv]
// ---------------------------------------------------------------------------
// Rainbow mapper port checker
// Port-level properties of the mapper, bound to the top level.
// ---------------------------------------------------------------------------
`include "rainbow_value_to_rgb_defines.svh"

module rvr_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [rvr_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [rvr_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input logic                                  csr_we,
   input logic [rvr_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input logic [rvr_pkg::SAMPLE_WIDTH-1:0]      csr_wdata
);

   logic [rvr_pkg::CHANNEL_BITS-1:0] red;
   logic [rvr_pkg::CHANNEL_BITS-1:0] green;
   logic [rvr_pkg::CHANNEL_BITS-1:0] blue;
   logic                             unused_inputs;

   assign red   = rsp_tdata[rvr_pkg::CHANNEL_BITS-1:0];
   assign green = rsp_tdata[2*rvr_pkg::CHANNEL_BITS-1:rvr_pkg::CHANNEL_BITS];
   assign blue  = rsp_tdata[3*rvr_pkg::CHANNEL_BITS-1:2*rvr_pkg::CHANNEL_BITS];
   assign unused_inputs = req_tvalid ^ (^req_tdata) ^ csr_we ^ (^csr_addr) ^ (^csr_wdata);

   // hold a stalled result
   `RVR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   // an empty output register never blocks the input
   `RVR_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   // every rainbow colour has one full channel and never mixes red with blue
   `RVR_ASSERT_NOW(a_rainbow_shape, clock, reset, rsp_tvalid,
      (red == '0 || blue == '0) &&
      (red == rvr_pkg::CHAN_MAX || green == rvr_pkg::CHAN_MAX ||
       blue == rvr_pkg::CHAN_MAX))
   // reset empties the pipeline
   `RVR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind rainbow_value_to_rgb rvr_checker u_checker (.*);
